// ----- rtl/fcull_pkg.sv -----
package fcull_pkg;

	localparam int COORD_WIDTH     = 22;
	localparam int NORMAL_WIDTH    = 14;
	localparam int PLANE_COUNT     = 6;
	localparam int PLANE_REG_WIDTH = 64;
	localparam int PLANE_IDX_WIDTH = 3;
	localparam int CFG_ADDR_WIDTH  = PLANE_IDX_WIDTH + 3;

	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_SPHERE = 2'd1,
		OP_CUBE   = 2'd2,
		OP_BOX    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		V_OUTSIDE   = 2'd0,
		V_INTERSECT = 2'd1,
		V_INSIDE    = 2'd2
	} verdict_t;

	typedef struct packed {
		logic outside;
		logic partial;
	} plane_flags_t;

endpackage

// ----- rtl/fcull_cfg_regs.sv -----
module fcull_cfg_regs (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [fcull_pkg::CFG_ADDR_WIDTH-1:0]      paddr,
	input  logic [fcull_pkg::PLANE_REG_WIDTH-1:0]     pwdata,
	output logic [fcull_pkg::PLANE_REG_WIDTH-1:0]     prdata,
	output logic                                      pready,
	output logic [fcull_pkg::PLANE_REG_WIDTH-1:0]     planes [fcull_pkg::PLANE_COUNT]
);

	logic [fcull_pkg::PLANE_IDX_WIDTH-1:0] idx;
	logic                                  idx_ok;
	logic [fcull_pkg::PLANE_REG_WIDTH-1:0] plane_q [fcull_pkg::PLANE_COUNT];

	assign idx    = paddr[fcull_pkg::CFG_ADDR_WIDTH-1:3];
	assign idx_ok = idx < fcull_pkg::PLANE_IDX_WIDTH'(fcull_pkg::PLANE_COUNT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && idx_ok) begin
			plane_q[idx] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = plane_q[idx];
		end
	end

	always_comb begin
		for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
			planes[i] = plane_q[i];
		end
	end

endmodule

// ----- rtl/fcull_plane_eval.sv -----
module fcull_plane_eval #(
	parameter int COORD_WIDTH  = fcull_pkg::COORD_WIDTH,
	parameter int NORMAL_WIDTH = fcull_pkg::NORMAL_WIDTH
) (
	input  logic [fcull_pkg::PLANE_REG_WIDTH-1:0] plane,
	input  fcull_pkg::op_t                        op,
	input  logic signed [COORD_WIDTH-1:0]         pos_x,
	input  logic signed [COORD_WIDTH-1:0]         pos_y,
	input  logic signed [COORD_WIDTH-1:0]         pos_z,
	input  logic [COORD_WIDTH-2:0]                extent,
	input  logic signed [COORD_WIDTH-1:0]         box_max_x,
	input  logic signed [COORD_WIDTH-1:0]         box_max_y,
	input  logic signed [COORD_WIDTH-1:0]         box_max_z,
	output fcull_pkg::plane_flags_t               flags
);

	localparam int PW   = 3 * NORMAL_WIDTH + COORD_WIDTH;
	localparam int PRW  = COORD_WIDTH + NORMAL_WIDTH;
	localparam int DW   = COORD_WIDTH + NORMAL_WIDTH + 3;
	localparam int FRAC = NORMAL_WIDTH - 2;

	logic [PW+fcull_pkg::PLANE_REG_WIDTH-1:0] plane_pad;
	logic signed [NORMAL_WIDTH-1:0]           n    [3];
	logic signed [COORD_WIDTH-1:0]            off;
	logic signed [COORD_WIDTH-1:0]            pmin [3];
	logic signed [COORD_WIDTH-1:0]            pmax [3];
	logic signed [COORD_WIDTH-1:0]            ext_pos;
	logic signed [COORD_WIDTH-1:0]            ext_neg;
	logic signed [COORD_WIDTH-1:0]            v    [3];
	logic signed [COORD_WIDTH-1:0]            w    [3];
	logic signed [PRW-1:0]                    pv   [3];
	logic signed [PRW-1:0]                    pw   [3];
	logic signed [DW-1:0]                     off_s;
	logic signed [DW-1:0]                     dot1;
	logic signed [DW-1:0]                     dot2;
	logic signed [DW-1:0]                     ext_s;

	assign plane_pad = {{PW{1'b0}}, plane};
	assign off       = signed'(plane_pad[3*NORMAL_WIDTH +: COORD_WIDTH]);
	assign pmin[0]   = pos_x;
	assign pmin[1]   = pos_y;
	assign pmin[2]   = pos_z;
	assign pmax[0]   = box_max_x;
	assign pmax[1]   = box_max_y;
	assign pmax[2]   = box_max_z;
	assign ext_pos   = signed'({1'b0, extent});
	assign ext_neg   = -ext_pos;
	assign ext_s     = DW'(ext_pos) <<< FRAC;
	assign off_s     = DW'(off) <<< FRAC;

	// box: v is the positive vertex, w the negative one
	// cube: w picks the sign of each normal so n.w = extent * sum |n|
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n[k] = signed'(plane_pad[k*NORMAL_WIDTH +: NORMAL_WIDTH]);
			if (op == fcull_pkg::OP_BOX) begin
				v[k] = n[k][NORMAL_WIDTH-1] ? pmin[k] : pmax[k];
				w[k] = n[k][NORMAL_WIDTH-1] ? pmax[k] : pmin[k];
			end else begin
				v[k] = pmin[k];
				w[k] = n[k][NORMAL_WIDTH-1] ? ext_neg : ext_pos;
			end
			pv[k] = n[k] * v[k];
			pw[k] = n[k] * w[k];
		end
	end

	assign dot1 = DW'(pv[0]) + DW'(pv[1]) + DW'(pv[2]) + off_s;
	assign dot2 = DW'(pw[0]) + DW'(pw[1]) + DW'(pw[2]);

	always_comb begin
		unique case (op)
			fcull_pkg::OP_POINT: begin
				flags.outside = dot1 <= 0;
				flags.partial = 1'b0;
			end
			fcull_pkg::OP_SPHERE: begin
				flags.outside = dot1 <= -ext_s;
				flags.partial = !(dot1 > ext_s);
			end
			fcull_pkg::OP_CUBE: begin
				flags.outside = (dot1 + dot2) <= 0;
				flags.partial = (dot1 - dot2) <= 0;
			end
			fcull_pkg::OP_BOX: begin
				flags.outside = dot1 < 0;
				flags.partial = (dot2 + off_s) <= 0;
			end
			default: begin
				flags.outside = 1'b0;
				flags.partial = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/frustum_cull_tester.sv -----
// Frustum cull tester: each beat carries one object (point, sphere, cube or
// axis-aligned box) that is tested against the six planes held in the 64-bit
// plane registers (right, left, bottom, top, far, near at byte addresses 0x00
// to 0x28). A new beat is taken every cycle unless the output register is full
// and stalled; a beat is held in the input register and its verdict is then
// captured in the output register. All six planes are evaluated in parallel by
// their own multiply-add lanes. Plane registers must only be written while no
// beat is in flight; the block itself does not enforce this.
module frustum_cull_tester #(
	parameter int COORD_WIDTH  = fcull_pkg::COORD_WIDTH,
	parameter int NORMAL_WIDTH = fcull_pkg::NORMAL_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fcull_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
	input  logic [fcull_pkg::PLANE_REG_WIDTH-1:0] pwdata,
	output logic [fcull_pkg::PLANE_REG_WIDTH-1:0] prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            op,
	input  logic signed [COORD_WIDTH-1:0]         pos_x,
	input  logic signed [COORD_WIDTH-1:0]         pos_y,
	input  logic signed [COORD_WIDTH-1:0]         pos_z,
	input  logic [COORD_WIDTH-2:0]                extent,
	input  logic signed [COORD_WIDTH-1:0]         box_max_x,
	input  logic signed [COORD_WIDTH-1:0]         box_max_y,
	input  logic signed [COORD_WIDTH-1:0]         box_max_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            verdict
);

	logic [fcull_pkg::PLANE_REG_WIDTH-1:0] planes [fcull_pkg::PLANE_COUNT];
	fcull_pkg::plane_flags_t               flags  [fcull_pkg::PLANE_COUNT];

	logic                          valid_s1;
	fcull_pkg::op_t                op_s1;
	logic signed [COORD_WIDTH-1:0] pos_x_s1;
	logic signed [COORD_WIDTH-1:0] pos_y_s1;
	logic signed [COORD_WIDTH-1:0] pos_z_s1;
	logic [COORD_WIDTH-2:0]        extent_s1;
	logic signed [COORD_WIDTH-1:0] box_max_x_s1;
	logic signed [COORD_WIDTH-1:0] box_max_y_s1;
	logic signed [COORD_WIDTH-1:0] box_max_z_s1;

	logic                  out_valid_q;
	fcull_pkg::verdict_t   verdict_q;
	fcull_pkg::verdict_t   verdict_nx;
	logic                  advance;
	logic                  accept;
	logic                  any_out;
	logic                  any_part;

	fcull_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= fcull_pkg::op_t'(op);
			pos_x_s1     <= pos_x;
			pos_y_s1     <= pos_y;
			pos_z_s1     <= pos_z;
			extent_s1    <= extent;
			box_max_x_s1 <= box_max_x;
			box_max_y_s1 <= box_max_y;
			box_max_z_s1 <= box_max_z;
		end
	end

	for (genvar i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin : g_plane
		fcull_plane_eval #(
			.COORD_WIDTH  (COORD_WIDTH),
			.NORMAL_WIDTH (NORMAL_WIDTH)
		) u_eval (
			.plane     (planes[i]),
			.op        (op_s1),
			.pos_x     (pos_x_s1),
			.pos_y     (pos_y_s1),
			.pos_z     (pos_z_s1),
			.extent    (extent_s1),
			.box_max_x (box_max_x_s1),
			.box_max_y (box_max_y_s1),
			.box_max_z (box_max_z_s1),
			.flags     (flags[i])
		);
	end

	always_comb begin
		any_out  = 1'b0;
		any_part = 1'b0;
		for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
			any_out  = any_out | flags[i].outside;
			any_part = any_part | flags[i].partial;
		end
		priority if (any_out) begin
			verdict_nx = fcull_pkg::V_OUTSIDE;
		end else if (any_part) begin
			verdict_nx = fcull_pkg::V_INTERSECT;
		end else begin
			verdict_nx = fcull_pkg::V_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			verdict_q <= verdict_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule

// ----- rtl/fcull_checker.sv -----
module fcull_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] verdict
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict))
		else $error("result beat changed while stalled");

	// input side only backs up when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an accepted beat reaches the output once the output can move
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("accepted beat did not reach the output");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict != 2'd3)
		else $error("invalid verdict code");

endmodule

bind frustum_cull_tester fcull_checker u_fcull_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.verdict   (verdict)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int COORD_WIDTH     = fcull_pkg::COORD_WIDTH;
	localparam int NORMAL_WIDTH    = fcull_pkg::NORMAL_WIDTH;
	localparam int PLANE_COUNT     = fcull_pkg::PLANE_COUNT;
	localparam int PLANE_REG_WIDTH = fcull_pkg::PLANE_REG_WIDTH;
	localparam int PLANE_IDX_WIDTH = fcull_pkg::PLANE_IDX_WIDTH;
	localparam int CFG_ADDR_WIDTH  = fcull_pkg::CFG_ADDR_WIDTH;
	localparam int CMAX = (1 << (COORD_WIDTH - 1)) - 1;
	localparam int CMIN = -(1 << (COORD_WIDTH - 1));
	localparam int NMAX = (1 << (NORMAL_WIDTH - 1)) - 1;
	localparam int NMIN = -(1 << (NORMAL_WIDTH - 1));
	localparam int ONE_N = 1 << (NORMAL_WIDTH - 2);
	localparam int HALF = 256000;
	localparam int PHASE_ITEMS = 95;

	typedef enum int {
		SET_ZERO,
		SET_AXIS,
		SET_TILTED,
		SET_RANDOM,
		SET_EXTREME
	} plane_set_t;

	class cull_board;
		logic [PLANE_REG_WIDTH-1:0] plane_reg [PLANE_COUNT];
		fcull_pkg::verdict_t verdict_q [$];
		int errors;
		int tally [3];
		longint nrm [3];
		longint ofs;

		function new();
			foreach (plane_reg[i])
				plane_reg[i] = '0;
			foreach (tally[i])
				tally[i] = 0;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function void set_plane(int idx, logic [PLANE_REG_WIDTH-1:0] val);
			if (idx < PLANE_COUNT)
				plane_reg[idx] = val;
		endfunction

		function void pick_plane(int i);
			nrm[0] = $signed(plane_reg[i][0 +: NORMAL_WIDTH]);
			nrm[1] = $signed(plane_reg[i][NORMAL_WIDTH +: NORMAL_WIDTH]);
			nrm[2] = $signed(plane_reg[i][2*NORMAL_WIDTH +: NORMAL_WIDTH]);
			ofs = $signed(plane_reg[i][3*NORMAL_WIDTH +: COORD_WIDTH]);
			ofs = ofs <<< (NORMAL_WIDTH - 2);
		endfunction

		function longint plane_dist(longint x, longint y, longint z);
			return nrm[0] * x + nrm[1] * y + nrm[2] * z + ofs;
		endfunction

		function fcull_pkg::verdict_t predict(fcull_pkg::op_t kind, longint p [3], longint ext,
				longint q [3]);
			longint ext_s;
			longint d;
			longint hi [3];
			longint lo [3];
			longint c [3];
			int cnt;
			bit gone;
			bit partial;
			gone = 0;
			partial = 0;
			ext_s = ext <<< (NORMAL_WIDTH - 2);
			for (int i = 0; i < PLANE_COUNT; i++) begin
				pick_plane(i);
				case (kind)
					fcull_pkg::OP_POINT: begin
						if (plane_dist(p[0], p[1], p[2]) <= 0)
							gone = 1;
					end
					fcull_pkg::OP_SPHERE: begin
						d = plane_dist(p[0], p[1], p[2]);
						if (d <= -ext_s)
							gone = 1;
						else if (!(d > ext_s))
							partial = 1;
					end
					fcull_pkg::OP_CUBE: begin
						cnt = 0;
						for (int k = 0; k < 8; k++) begin
							c[0] = k[0] ? p[0] + ext : p[0] - ext;
							c[1] = k[1] ? p[1] + ext : p[1] - ext;
							c[2] = k[2] ? p[2] + ext : p[2] - ext;
							if (plane_dist(c[0], c[1], c[2]) > 0)
								cnt++;
						end
						if (cnt == 0)
							gone = 1;
						else if (cnt != 8)
							partial = 1;
					end
					default: begin
						for (int k = 0; k < 3; k++) begin
							if (nrm[k] < 0) begin
								hi[k] = p[k];
								lo[k] = q[k];
							end else begin
								hi[k] = q[k];
								lo[k] = p[k];
							end
						end
						if (plane_dist(hi[0], hi[1], hi[2]) < 0)
							gone = 1;
						else if (plane_dist(lo[0], lo[1], lo[2]) <= 0)
							partial = 1;
					end
				endcase
				if (gone)
					break;
			end
			if (gone)
				return fcull_pkg::V_OUTSIDE;
			return partial ? fcull_pkg::V_INTERSECT : fcull_pkg::V_INSIDE;
		endfunction

		function void note_object(logic [1:0] kind,
				logic signed [COORD_WIDTH-1:0] px, logic signed [COORD_WIDTH-1:0] py,
				logic signed [COORD_WIDTH-1:0] pz, logic [COORD_WIDTH-2:0] ext,
				logic signed [COORD_WIDTH-1:0] qx, logic signed [COORD_WIDTH-1:0] qy,
				logic signed [COORD_WIDTH-1:0] qz);
			longint p [3];
			longint q [3];
			longint e;
			fcull_pkg::verdict_t v;
			p[0] = px;
			p[1] = py;
			p[2] = pz;
			q[0] = qx;
			q[1] = qy;
			q[2] = qz;
			e = ext;
			v = predict(fcull_pkg::op_t'(kind), p, e, q);
			tally[v]++;
			verdict_q.push_back(v);
		endfunction

		task check_verdict(logic [1:0] got);
			fcull_pkg::verdict_t want;
			if (verdict_q.size() == 0) begin
				report($sformatf("verdict %0d with no object outstanding", got));
				return;
			end
			want = verdict_q.pop_front();
			if (got !== want)
				report($sformatf("verdict %0d, predicted %0d", got, want));
		endtask

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_WIDTH-1:0] paddr;
	logic [PLANE_REG_WIDTH-1:0] pwdata;
	logic [PLANE_REG_WIDTH-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic [COORD_WIDTH-2:0] extent;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;
	logic out_valid;
	logic out_stall;
	logic [1:0] verdict;

	cull_board sb;
	int send_idle;
	int recv_idle;
	int sets_loaded;

	frustum_cull_tester dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.extent(extent),
		.box_max_x(box_max_x),
		.box_max_y(box_max_y),
		.box_max_z(box_max_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_object(op, pos_x, pos_y, pos_z, extent, box_max_x, box_max_y, box_max_z);
		if (arst_n && out_valid && !out_stall)
			sb.check_verdict(verdict);
	end

	function int clip_coord(longint v);
		if (v > CMAX)
			return CMAX;
		if (v < CMIN)
			return CMIN;
		return int'(v);
	endfunction

	function int rand_span(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function int pick_extreme(int lo, int hi);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	function logic [PLANE_REG_WIDTH-1:0] pack_plane(int nx, int ny, int nz, int off);
		return {off[COORD_WIDTH-1:0], nz[NORMAL_WIDTH-1:0], ny[NORMAL_WIDTH-1:0],
			nx[NORMAL_WIDTH-1:0]};
	endfunction

	task apb_xfer(input bit wr, input logic [PLANE_IDX_WIDTH-1:0] idx,
			input logic [PLANE_REG_WIDTH-1:0] val, output logic [PLANE_REG_WIDTH-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task program_plane(input int idx, input logic [PLANE_REG_WIDTH-1:0] val);
		logic [PLANE_REG_WIDTH-1:0] rd;
		apb_xfer(1'b1, idx[PLANE_IDX_WIDTH-1:0], val, rd);
		sb.set_plane(idx, val);
		apb_xfer(1'b0, idx[PLANE_IDX_WIDTH-1:0], '0, rd);
		if (rd !== val)
			sb.report($sformatf("plane %0d reads %h, wrote %h", idx, rd, val));
	endtask

	task load_planes(input plane_set_t pset, input int hw);
		int sgn;
		int off;
		int nv [3];
		logic [PLANE_REG_WIDTH-1:0] val;
		logic [PLANE_REG_WIDTH-1:0] rd;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			case (pset)
				SET_ZERO: val = '0;
				SET_AXIS, SET_TILTED: begin
					sgn = (i == 0 || i == 3 || i == 4) ? -1 : 1;
					for (int k = 0; k < 3; k++)
						nv[k] = (pset == SET_TILTED) ? int'($urandom_range(1200)) - 600 : 0;
					nv[i / 2] = nv[i / 2] + sgn * ONE_N;
					off = hw;
					if (pset == SET_TILTED)
						off = clip_coord(hw + rand_span(hw / 4));
					val = pack_plane(nv[0], nv[1], nv[2], off);
				end
				SET_RANDOM: val = {$urandom, $urandom};
				default: begin
					for (int k = 0; k < 3; k++)
						nv[k] = pick_extreme(NMIN, NMAX);
					val = pack_plane(nv[0], nv[1], nv[2], pick_extreme(CMIN, CMAX));
				end
			endcase
			program_plane(i, val);
		end
		// writes past the last plane must be dropped
		if (pset == SET_EXTREME) begin
			apb_xfer(1'b1, 3'd6, {$urandom, $urandom}, rd);
			apb_xfer(1'b1, 3'd7, {$urandom, $urandom}, rd);
		end
		sets_loaded++;
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task send_obj(input fcull_pkg::op_t kind, input int px, input int py, input int pz,
			input int ext, input int qx, input int qy, input int qz);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		pos_x <= px[COORD_WIDTH-1:0];
		pos_y <= py[COORD_WIDTH-1:0];
		pos_z <= pz[COORD_WIDTH-1:0];
		extent <= ext[COORD_WIDTH-2:0];
		box_max_x <= qx[COORD_WIDTH-1:0];
		box_max_y <= qy[COORD_WIDTH-1:0];
		box_max_z <= qz[COORD_WIDTH-1:0];
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task send_random(input int hw);
		fcull_pkg::op_t kind;
		int span;
		int px, py, pz, ext, qx, qy, qz;
		kind = fcull_pkg::op_t'($urandom_range(3));
		if ($urandom_range(9) == 0) begin
			px = $urandom;
			py = $urandom;
			pz = $urandom;
			ext = $urandom;
			qx = $urandom;
			qy = $urandom;
			qz = $urandom;
		end else begin
			span = clip_coord(hw + hw / 2 + 256);
			px = rand_span(span);
			py = rand_span(span);
			pz = rand_span(span);
			if ($urandom_range(3) == 0)
				ext = $urandom_range(64);
			else
				ext = $urandom_range(hw / 2 + 1);
			qx = clip_coord(longint'(px) + int'($urandom_range(hw)));
			qy = clip_coord(longint'(py) + int'($urandom_range(hw)));
			qz = clip_coord(longint'(pz) + int'($urandom_range(hw)));
			// occasionally inverted on one axis
			if ($urandom_range(9) == 0)
				qy = clip_coord(longint'(py) - int'($urandom_range(hw)));
		end
		send_obj(kind, px, py, pz, ext, qx, qy, qz);
	endtask

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int guard;
		plane_set_t order [6];
		sb = new();
		sets_loaded = 0;
		send_idle = 10;
		recv_idle = 79;
		order = '{SET_AXIS, SET_TILTED, SET_EXTREME, SET_TILTED, SET_RANDOM, SET_ZERO};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		op <= fcull_pkg::OP_POINT;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		extent <= '0;
		box_max_x <= '0;
		box_max_y <= '0;
		box_max_z <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes at reset: distance is zero everywhere
		send_obj(fcull_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, 100, -100, 5, 100, 0, 0, 0);
		send_obj(fcull_pkg::OP_CUBE, 0, 0, 0, 50, 0, 0, 0);
		send_obj(fcull_pkg::OP_BOX, -10, -10, -10, 0, 10, 10, 10);
		wait_drained();

		load_planes(SET_AXIS, HALF);
		send_obj(fcull_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0);
		send_obj(fcull_pkg::OP_POINT, HALF, 0, 0, 0, 0, 0, 0);
		send_obj(fcull_pkg::OP_POINT, HALF - 1, 0, 0, CMAX, CMIN, CMAX, CMIN);
		send_obj(fcull_pkg::OP_POINT, CMIN, CMAX, 0, 0, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, 0, 0, 0, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, HALF, 0, 0, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, HALF + 1000, 0, 0, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, HALF + 999, 0, 0, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_SPHERE, 0, 0, 0, 0, CMAX, CMAX, CMAX);
		send_obj(fcull_pkg::OP_SPHERE, 0, 0, 0, CMAX, 0, 0, 0);
		send_obj(fcull_pkg::OP_CUBE, 0, 0, 0, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_CUBE, 0, HALF, 0, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_CUBE, 0, 0, HALF + 1000, 1000, 0, 0, 0);
		send_obj(fcull_pkg::OP_CUBE, CMAX, CMIN, 0, CMAX, 0, 0, 0);
		send_obj(fcull_pkg::OP_CUBE, 0, 0, 0, 0, 0, 0, 0);
		send_obj(fcull_pkg::OP_BOX, -1000, -1000, -1000, 0, 1000, 1000, 1000);
		send_obj(fcull_pkg::OP_BOX, 0, 0, 0, 0, HALF + 5, 10, 10);
		send_obj(fcull_pkg::OP_BOX, HALF + 1, 0, 0, 0, HALF + 500, 10, 10);
		send_obj(fcull_pkg::OP_BOX, HALF, 0, 0, 0, HALF + 500, 10, 10);
		send_obj(fcull_pkg::OP_BOX, 1000, 1000, 1000, 0, -1000, -1000, -1000);
		send_obj(fcull_pkg::OP_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);

		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin
					send_idle = 10;
					recv_idle = 79;
				end
				1: begin
					send_idle = 79;
					recv_idle = 10;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int s = 0; s < 6; s++) begin
				int hw;
				hw = $urandom_range(20000, 1500000);
				wait_drained();
				load_planes(order[s], hw);
				for (int n = 0; n < PHASE_ITEMS; n++) begin
					if (s == 0 && n == PHASE_ITEMS / 2)
						wait_drained();
					send_random(hw);
				end
			end
		end

		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
		$display("covered %0d objects over %0d plane sets", sb.tally[0] + sb.tally[1] +
			sb.tally[2], sets_loaded);
		$display("verdicts: %0d outside, %0d intersecting, %0d inside; %0d mismatches",
			sb.tally[0], sb.tally[1], sb.tally[2], sb.errors);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
